// ===== design/tpsd_pkg.sv =====
// Shared types and constants for the targa pixel stream decoder.
// Used by targa_pixel_stream_decoder; no other dependencies.
`default_nettype none

package tpsd_pkg;

   // Palette storage
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
   localparam int LIMIT_W       = PAL_AW + 1;
   localparam int PAL_DW        = 32;

   // Map entry counter saturates at its all-ones value
   localparam int           ENTRY_W   = 17;
   localparam logic [16:0]  ENTRY_MAX = 17'h1FFFF;

   localparam int MAP_LEFT_W = 18;
   localparam int CSR_IDX_W  = 3;

   localparam logic [6:0] PKT_COUNT_MASK = 7'd127;
   localparam logic [7:0] PKT_MAX_COUNT  = 8'd128;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_BYTES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_BYTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_ORIGIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PIXELS  = 3'd5;

   typedef enum logic [1:0] {
      PH_MAP    = 2'd0,
      PH_HEADER = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

endpackage

`default_nettype wire

// ===== design/tpsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the decoder palette.
`default_nettype none

module tpsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/targa_pixel_stream_decoder.sv =====
// Targa pixel stream decoder top level: colour map capture, RLE packet parse,
// pixel gather and palette lookup. Depends on tpsd_pkg and tpsd_ram.
//
// Usage:
//  - req channel: one stream byte per request (req_data_byte), the bytes that
//    follow the header and ID field. A frame starts with the first byte after
//    reset or after the result that carried rsp_frame_done.
//  - rsp channel: one result per completed pixel or palette index, with the
//    pixel value, its repeat count (1..128), frame_done and bad_index.
//    Map bytes, packet bytes and partial pixels produce no result.
//  - csr port: write-only, index 0..5 = mode, pixel_bytes, entry_bytes,
//    map_count, map_origin, num_pixels. Write only while the block is idle.
//  - Throughput: one request per cycle while req_ready is high. Each byte gets a
//    small state update and at most one palette read in the cycle it is taken.
//  - Pipeline: the request that completes a result is followed by the registered
//    palette read stage and then the output register, where the result appears.
//  - Stall: the output register and the palette read stage each hold one
//    result; with both full and rsp_ready low, req_ready drops.
//  - Reset: synchronous; clears all control state and registers to their
//    defaults. Palette contents are undefined until written, but never read
//    before they are written in the current frame.
`default_nettype none

module targa_pixel_stream_decoder
   import tpsd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_data_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [31:0]               rsp_pixel,
   output logic [7:0]                rsp_repeat_res,
   output logic                      rsp_frame_done,
   output logic                      rsp_bad_index,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   // Configuration registers
   logic [1:0]  mode_ff;
   logic [2:0]  pixel_bytes_ff;
   logic [2:0]  entry_bytes_ff;
   logic [15:0] map_count_ff;
   logic [15:0] map_origin_ff;
   logic [31:0] num_pixels_ff;

   // Frame state
   phase_type              phase_ff, phase_in;
   logic [MAP_LEFT_W-1:0]  map_left_ff, map_left_in;
   logic [23:0]            gather_ff, gather_in;
   logic [1:0]             gcount_ff, gcount_in;
   logic [7:0]             packet_left_ff, packet_left_in;
   logic                   packet_run_ff, packet_run_in;
   logic [31:0]            pixels_left_ff, pixels_left_in;
   logic [ENTRY_W-1:0]     entry_ff, entry_in;

   // Palette read stage
   logic        s1_valid_ff;
   logic [31:0] s1_value_ff;
   logic        s1_use_ram_ff;
   logic [7:0]  s1_rep_ff;
   logic        s1_done_ff;
   logic        s1_bad_ff;

   // Output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_pixel_ff;
   logic [7:0]  rsp_rep_ff;
   logic        rsp_done_ff;
   logic        rsp_bad_ff;

   logic mapped, rle, accept, out_free, s1_adv;
   logic [2:0] ebytes, pbytes, g_size;

   // State as seen by this request, after frame start and map skip
   logic                   start;
   phase_type              e_phase;
   logic [MAP_LEFT_W-1:0]  e_map_left;
   logic [23:0]            e_gword;
   logic [1:0]             e_gcount;
   logic [7:0]             e_packet;
   logic                   e_run;
   logic [31:0]            e_pixels;
   logic [ENTRY_W-1:0]     e_entry;
   logic [MAP_LEFT_W-1:0]  map_total;

   logic [31:0]        g_full;
   logic               g_done;
   logic [1:0]         g_count_next;
   logic [32:0]        pal_addr;
   logic [LIMIT_W-1:0] limit;
   logic               entry_room;
   logic [7:0]         rep0, rep;
   logic [31:0]        pixels_after;
   logic [7:0]         packet_after;
   logic [7:0]         hdr_rep;

   logic        res_valid, res_bad, res_done, res_use_ram;
   logic [31:0] res_value;
   logic        wr_en, rd_en;
   logic [31:0] ram_rdata;

   assign mapped = mode_ff[0];
   assign rle    = mode_ff[1];

   assign ebytes = (entry_bytes_ff > 3'd4) ? 3'd4 : entry_bytes_ff;
   assign pbytes = (pixel_bytes_ff == 3'd0) ? 3'd1 :
                   (pixel_bytes_ff > 3'd4) ? 3'd4 : pixel_bytes_ff;

   // Handshake: palette stage moves on when the output register is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign start     = (pixels_left_ff == 32'd0);
   assign map_total = MAP_LEFT_W'(ebytes * map_count_ff);

   always_comb begin
      phase_type p;
      p          = start ? PH_MAP : phase_ff;
      e_map_left = start ? map_total : map_left_ff;
      e_pixels   = start ? ((num_pixels_ff == 32'd0) ? 32'd1 : num_pixels_ff)
                         : pixels_left_ff;
      e_packet   = start ? 8'd0 : packet_left_ff;
      e_run      = start ? 1'b0 : packet_run_ff;
      e_entry    = start ? '0 : entry_ff;
      e_gword    = start ? 24'd0 : gather_ff;
      e_gcount   = start ? 2'd0 : gcount_ff;
      e_phase    = p;
      // Map done (or empty): move on to packets or raw pixels
      if (p == PH_MAP && e_map_left == '0) begin
         e_phase  = rle ? PH_HEADER : PH_DATA;
         e_gword  = 24'd0;
         e_gcount = 2'd0;
      end
   end

   // Little-endian byte gather, shared by map entries and pixels
   assign g_size       = (e_phase == PH_MAP) ? ebytes : pbytes;
   assign g_full       = {8'd0, e_gword} | ({24'd0, req_data_byte} << {e_gcount, 3'b000});
   assign g_done       = ({1'b0, e_gcount} + 3'd1) >= g_size;
   assign g_count_next = g_done ? 2'd0 : e_gcount + 2'd1;

   // Palette address check
   assign entry_room = e_entry < ENTRY_W'(PALETTE_DEPTH);
   assign limit      = entry_room ? LIMIT_W'(e_entry) : LIMIT_W'(PALETTE_DEPTH);
   assign pal_addr   = {1'b0, g_full} + {17'd0, map_origin_ff};

   // Repeat count, clamped to the pixels left in the frame
   assign rep0 = (rle && e_run && e_packet != 8'd0) ? e_packet : 8'd1;
   assign rep  = ({24'd0, rep0} > e_pixels) ? e_pixels[7:0] : rep0;
   assign pixels_after = e_pixels - {24'd0, rep};
   assign packet_after = e_run ? 8'd0 :
                         (e_packet != 8'd0) ? e_packet - 8'd1 : 8'd0;
   assign hdr_rep = {1'b0, req_data_byte[6:0] & PKT_COUNT_MASK} + 8'd1;

   // Next state
   always_comb begin
      phase_in       = e_phase;
      map_left_in    = e_map_left;
      gather_in      = e_gword;
      gcount_in      = e_gcount;
      packet_left_in = e_packet;
      packet_run_in  = e_run;
      pixels_left_in = e_pixels;
      entry_in       = e_entry;
      case (e_phase)
         PH_MAP: begin
            if (mapped) begin
               gather_in = g_done ? 24'd0 : g_full[23:0];
               gcount_in = g_count_next;
               if (g_done && e_entry != ENTRY_MAX) begin
                  entry_in = e_entry + ENTRY_W'(1);
               end
            end
            map_left_in = e_map_left - MAP_LEFT_W'(1);
         end
         PH_HEADER: begin
            packet_run_in  = req_data_byte[7];
            packet_left_in = ({24'd0, hdr_rep} < e_pixels) ? hdr_rep : e_pixels[7:0];
            phase_in       = PH_DATA;
            gather_in      = 24'd0;
            gcount_in      = 2'd0;
         end
         PH_DATA: begin
            gather_in = g_done ? 24'd0 : g_full[23:0];
            gcount_in = g_count_next;
            if (g_done) begin
               pixels_left_in = pixels_after;
               if (rle) begin
                  packet_left_in = packet_after;
                  if (packet_after == 8'd0) begin
                     phase_in = PH_HEADER;
                  end
               end
               // Frame complete: go idle until the next byte
               if (pixels_after == 32'd0) begin
                  phase_in       = PH_MAP;
                  map_left_in    = '0;
                  packet_left_in = 8'd0;
                  packet_run_in  = 1'b0;
               end
            end
         end
         default: begin
            phase_in = e_phase;
         end
      endcase
   end

   // Result and palette port controls
   always_comb begin
      res_valid   = (e_phase == PH_DATA) && g_done;
      res_bad     = mapped && (pal_addr >= {{(33 - LIMIT_W){1'b0}}, limit});
      res_use_ram = mapped && !res_bad;
      res_value   = res_bad ? 32'd0 : g_full;
      res_done    = (pixels_after == 32'd0);
      wr_en       = accept && (e_phase == PH_MAP) && mapped && g_done && entry_room;
      rd_en       = accept && res_valid && res_use_ram;
   end

   tpsd_ram #(
      .WIDTH (PAL_DW),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (e_entry[PAL_AW-1:0]),
      .wr_data (g_full),
      .rd_en   (rd_en),
      .rd_addr (pal_addr[PAL_AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 2'd0;
         pixel_bytes_ff <= 3'd3;
         entry_bytes_ff <= 3'd0;
         map_count_ff   <= 16'd0;
         map_origin_ff  <= 16'd0;
         num_pixels_ff  <= 32'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:        mode_ff        <= csr_wdata[1:0];
            CSR_PIXEL_BYTES: pixel_bytes_ff <= csr_wdata[2:0];
            CSR_ENTRY_BYTES: entry_bytes_ff <= csr_wdata[2:0];
            CSR_MAP_COUNT:   map_count_ff   <= csr_wdata[15:0];
            CSR_MAP_ORIGIN:  map_origin_ff  <= csr_wdata[15:0];
            CSR_NUM_PIXELS:  num_pixels_ff  <= csr_wdata;
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   // Frame state, advanced once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAP;
         map_left_ff    <= '0;
         gather_ff      <= 24'd0;
         gcount_ff      <= 2'd0;
         packet_left_ff <= 8'd0;
         packet_run_ff  <= 1'b0;
         pixels_left_ff <= 32'd0;
         entry_ff       <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         map_left_ff    <= map_left_in;
         gather_ff      <= gather_in;
         gcount_ff      <= gcount_in;
         packet_left_ff <= packet_left_in;
         packet_run_ff  <= packet_run_in;
         pixels_left_ff <= pixels_left_in;
         entry_ff       <= entry_in;
      end
   end

   // Palette read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= res_valid;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff   <= res_value;
         s1_use_ram_ff <= res_use_ram;
         s1_rep_ff     <= rep;
         s1_done_ff    <= res_done;
         s1_bad_ff     <= res_bad;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pixel_ff <= s1_use_ram_ff ? ram_rdata : s1_value_ff;
         rsp_rep_ff   <= s1_rep_ff;
         rsp_done_ff  <= s1_done_ff;
         rsp_bad_ff   <= s1_bad_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel      = rsp_pixel_ff;
   assign rsp_repeat_res = rsp_rep_ff;
   assign rsp_frame_done = rsp_done_ff;
   assign rsp_bad_index  = rsp_bad_ff;

   // Checks
   a_rep_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_rep_ff != 8'd0) && (rsp_rep_ff <= PKT_MAX_COUNT))
      else $error("repeat count out of range");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_pixel_ff == 32'd0)
      else $error("bad palette index with nonzero pixel");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      accept && res_valid && res_done |=> pixels_left_ff == 32'd0)
      else $error("frame not closed after last pixel");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken with both stages full");

endmodule

`default_nettype wire

// ===== tb/sv/targa_pixel_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for targa_pixel_stream_decoder: streams colour maps and raw or
// RLE pixel data under many register settings and checks each pixel against a decoder
// kept in the bench. Depends on tpsd_pkg and the decoder RTL.

module targa_pixel_stream_decoder_test
   import tpsd_pkg::*;
();

   localparam int     ITEM_TARGET   = 1400;
   localparam int     SETTLE_CYCLES = 4;
   localparam longint CYCLE_LIMIT   = 1_000_000;

   localparam logic [1:0] MODE_TRUECOLOR  = 2'd0;
   localparam logic [1:0] MODE_MAPPED     = 2'd1;
   localparam logic [1:0] MODE_RLE        = 2'd2;
   localparam logic [1:0] MODE_MAPPED_RLE = 2'd3;

   typedef struct packed {
      logic [31:0] pixel;
      logic [7:0]  repeat_cnt;
      logic        frame_done;
      logic        bad_index;
   } pixel_result_type;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_data_byte = 8'd0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [31:0]          rsp_pixel;
   logic [7:0]           rsp_repeat_res;
   logic                 rsp_frame_done;
   logic                 rsp_bad_index;
   logic                 csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = CSR_MODE;
   logic [31:0]          csr_wdata     = 32'd0;

   // Register copies, updated on the same edge as the block
   logic [1:0]  cfg_mode;
   logic [2:0]  cfg_pixel_bytes;
   logic [2:0]  cfg_entry_bytes;
   logic [15:0] cfg_map_count;
   logic [15:0] cfg_map_origin;
   logic [31:0] cfg_num_pixels;

   // Decoder state
   phase_type   dec_phase;
   logic [17:0] map_left;
   logic [31:0] gather_word;
   logic [1:0]  gather_count;
   logic [7:0]  packet_left;
   logic        packet_is_run;
   logic [31:0] pixels_left;
   logic [16:0] entries_seen;
   logic [31:0] color_lut [PALETTE_DEPTH];

   pixel_result_type pending_pixels [$];
   logic [7:0]       stream_bytes [$];

   int     error_count = 0;
   int     stim_bytes  = 0;
   int     idle_pct    = 0;
   int     req_gap     = 0;
   int     stall_left  = 0;
   logic   req_taken   = 1'b0;
   longint cycle_count = 0;

   targa_pixel_stream_decoder i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel      (rsp_pixel),
      .rsp_repeat_res (rsp_repeat_res),
      .rsp_frame_done (rsp_frame_done),
      .rsp_bad_index  (rsp_bad_index),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int clamp_size(input logic [2:0] v, input int lo);
      if (int'(v) < lo) return lo;
      return (v > 3'd4) ? 4 : int'(v);
   endfunction

   function automatic void clear_decoder();
      cfg_mode        = MODE_TRUECOLOR;
      cfg_pixel_bytes = 3'd3;
      cfg_entry_bytes = 3'd0;
      cfg_map_count   = 16'd0;
      cfg_map_origin  = 16'd0;
      cfg_num_pixels  = 32'd1;
      dec_phase       = PH_MAP;
      map_left        = '0;
      gather_word     = '0;
      gather_count    = '0;
      packet_left     = '0;
      packet_is_run   = 1'b0;
      pixels_left     = '0;
      entries_seen    = '0;
      for (int i = 0; i < PALETTE_DEPTH; i++) color_lut[i] = '0;
   endfunction

   // Append one byte little-endian; true once size bytes are in
   function automatic logic gather_le(input logic [7:0] b, input int size);
      gather_word |= 32'(b) << (8 * gather_count);
      if (int'(gather_count) + 1 >= size) begin
         gather_count = 2'd0;
         return 1'b1;
      end
      gather_count++;
      return 1'b0;
   endfunction

   function automatic logic decode_byte(input logic [7:0] b, output pixel_result_type res);
      logic        mapped;
      logic        rle;
      int          ebytes;
      int          pbytes;
      logic [7:0]  count;
      logic [31:0] rep;
      logic [16:0] limit;
      logic [32:0] addr;
      mapped = cfg_mode[0];
      rle    = cfg_mode[1];
      ebytes = clamp_size(cfg_entry_bytes, 0);
      pbytes = clamp_size(cfg_pixel_bytes, 1);
      res    = '0;
      if (pixels_left == 0) begin
         map_left      = 18'(ebytes) * 18'(cfg_map_count);
         pixels_left   = (cfg_num_pixels == 0) ? 32'd1 : cfg_num_pixels;
         dec_phase     = PH_MAP;
         gather_word   = '0;
         gather_count  = '0;
         packet_left   = '0;
         packet_is_run = 1'b0;
         entries_seen  = '0;
      end
      if (dec_phase == PH_MAP && map_left == 0) begin
         dec_phase    = rle ? PH_HEADER : PH_DATA;
         gather_word  = '0;
         gather_count = '0;
      end
      if (dec_phase == PH_MAP) begin
         // truecolour frames skip the map; entries past the palette are dropped
         if (mapped) begin
            if (gather_le(b, ebytes)) begin
               if (entries_seen < PALETTE_DEPTH)
                  color_lut[entries_seen[PAL_AW-1:0]] = gather_word;
               if (entries_seen != ENTRY_MAX) entries_seen++;
               gather_word = '0;
            end
         end
         map_left--;
         return 1'b0;
      end
      if (dec_phase == PH_HEADER) begin
         count         = {1'b0, b[6:0] & PKT_COUNT_MASK} + 8'd1;
         packet_is_run = b[7];
         packet_left   = (32'(count) < pixels_left) ? count : pixels_left[7:0];
         dec_phase     = PH_DATA;
         gather_word   = '0;
         gather_count  = '0;
         return 1'b0;
      end
      if (!gather_le(b, pbytes)) return 1'b0;
      res.pixel   = gather_word;
      gather_word = '0;
      if (mapped) begin
         limit = (entries_seen < PALETTE_DEPTH) ? entries_seen : 17'(PALETTE_DEPTH);
         addr  = 33'(res.pixel) + 33'(cfg_map_origin);
         if (addr < 33'(limit)) begin
            res.pixel = color_lut[addr[PAL_AW-1:0]];
         end else begin
            res.pixel     = '0;
            res.bad_index = 1'b1;
         end
      end
      rep = 32'd1;
      if (rle && packet_is_run && packet_left != 0) rep = 32'(packet_left);
      if (rep > pixels_left) rep = pixels_left;
      pixels_left -= rep;
      if (rle) begin
         if (packet_is_run) packet_left = '0;
         else if (packet_left != 0) packet_left--;
         if (packet_left == 0) dec_phase = PH_HEADER;
      end
      res.repeat_cnt = rep[7:0];
      if (pixels_left == 0) begin
         res.frame_done = 1'b1;
         dec_phase      = PH_MAP;
         map_left       = '0;
         packet_left    = '0;
         packet_is_run  = 1'b0;
      end
      return 1'b1;
   endfunction

   // Predict on each accepted request, check each accepted result
   always @(posedge clock) begin : rsp_check
      pixel_result_type want;
      if (reset) begin
         clear_decoder();
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("result with no pixel pending: pixel %h", rsp_pixel);
               error_count++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel !== want.pixel) begin
                  $error("pixel: expected %h, got %h", want.pixel, rsp_pixel);
                  error_count++;
               end
               if (rsp_repeat_res !== want.repeat_cnt) begin
                  $error("repeat_res: expected %0d, got %0d", want.repeat_cnt, rsp_repeat_res);
                  error_count++;
               end
               if (rsp_frame_done !== want.frame_done) begin
                  $error("frame_done: expected %b, got %b", want.frame_done, rsp_frame_done);
                  error_count++;
               end
               if (rsp_bad_index !== want.bad_index) begin
                  $error("bad_index: expected %b, got %b", want.bad_index, rsp_bad_index);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE:        cfg_mode        = csr_wdata[1:0];
               CSR_PIXEL_BYTES: cfg_pixel_bytes = csr_wdata[2:0];
               CSR_ENTRY_BYTES: cfg_entry_bytes = csr_wdata[2:0];
               CSR_MAP_COUNT:   cfg_map_count   = csr_wdata[15:0];
               CSR_MAP_ORIGIN:  cfg_map_origin  = csr_wdata[15:0];
               CSR_NUM_PIXELS:  cfg_num_pixels  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (decode_byte(req_data_byte, want)) pending_pixels.push_back(want);
         end
         req_taken <= req_valid && req_ready;
      end
   end

   // Request driver: hold the byte until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (stream_bytes.size() != 0) begin
            req_valid     <= 1'b1;
            req_data_byte <= stream_bytes.pop_front();
            if ($urandom_range(0, 99) < idle_pct) req_gap = $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
      stim_bytes++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (stream_bytes.size() != 0 || req_valid || pending_pixels.size() != 0);
   endtask

   // Bytes without a result may still be in flight after the last pixel
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_all(input logic [1:0] mode, input logic [2:0] pbytes,
                            input logic [2:0] ebytes, input logic [15:0] count,
                            input logic [15:0] origin, input logic [31:0] npix);
      write_reg(CSR_MODE, 32'(mode));
      write_reg(CSR_PIXEL_BYTES, 32'(pbytes));
      write_reg(CSR_ENTRY_BYTES, 32'(ebytes));
      write_reg(CSR_MAP_COUNT, 32'(count));
      write_reg(CSR_MAP_ORIGIN, 32'(origin));
      write_reg(CSR_NUM_PIXELS, npix);
   endtask

   // One pixel or index; mapped frames mostly use indexes that hit the palette
   task automatic push_value(input int stored);
      logic [31:0] v;
      int          pbytes;
      pbytes = clamp_size(cfg_pixel_bytes, 1);
      if (cfg_mode[0] && stored > int'(cfg_map_origin) && $urandom_range(0, 7) != 0) begin
         v = $urandom_range(0, stored - 1 - int'(cfg_map_origin));
      end else begin
         case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom;
         endcase
      end
      for (int k = 0; k < pbytes; k++) push_byte(v[8*k +: 8]);
   endtask

   task automatic push_frame();
      int     ebytes;
      int     stored;
      int     packet;
      int     taken;
      longint remaining;
      logic   run;
      ebytes = clamp_size(cfg_entry_bytes, 0);
      stored = 0;
      if (cfg_mode[0] && ebytes != 0)
         stored = (cfg_map_count < PALETTE_DEPTH) ? int'(cfg_map_count) : PALETTE_DEPTH;
      repeat (ebytes * int'(cfg_map_count)) push_byte(8'($urandom));
      remaining = (cfg_num_pixels == 0) ? 1 : longint'(cfg_num_pixels);
      while (remaining > 0) begin
         if (!cfg_mode[1]) begin
            push_value(stored);
            remaining--;
         end else begin
            packet = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            run    = 1'($urandom_range(0, 1));
            push_byte({run, 7'(packet - 1)});
            taken  = (packet < remaining) ? packet : int'(remaining);
            if (run) push_value(stored);
            else repeat (taken) push_value(stored);
            remaining -= taken;
         end
      end
   endtask

   // Feed single bytes until the current frame closes
   task automatic finish_frame();
      while (pixels_left != 0) begin
         push_byte(8'($urandom));
         wait_drained();
      end
   endtask

   initial begin : stimulus
      logic [1:0]  mode;
      logic [2:0]  pbytes;
      logic [2:0]  ebytes;
      logic [15:0] count;
      logic [15:0] origin;
      logic [31:0] npix;
      int          phase_start;
      int          packet;
      logic        run;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: one 3-byte truecolour pixel per frame, all zeros then all ones
      idle_pct = 20;
      push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
      push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
      settle();

      // Mapped RLE: bad palette address, then a run clamped to the frame end
      write_all(MODE_MAPPED_RLE, 3'd1, 3'd2, 16'd2, 16'd1, 32'd3);
      push_byte(8'h11); push_byte(8'h22); push_byte(8'h33); push_byte(8'h44);
      push_byte(8'h00); push_byte(8'h01);
      push_byte(8'hFF); push_byte(8'h00);
      settle();

      // Widen the pixel size in the middle of a frame
      write_all(MODE_TRUECOLOR, 3'd1, 3'd0, 16'd0, 16'd0, 32'd3);
      push_byte(8'h5A);
      settle();
      write_reg(CSR_PIXEL_BYTES, 32'd7);
      push_byte(8'h01); push_byte(8'h02); push_byte(8'h03); push_byte(8'h04);
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00);
      settle();

      while (stim_bytes < ITEM_TARGET) begin
         mode   = 2'($urandom_range(0, 3));
         pbytes = 3'($urandom_range(0, 7));
         ebytes = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: begin
               count  = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
               ebytes = 3'd0;
            end
            1: begin
               // as many entries as the palette holds, or more
               count  = 16'($urandom_range(256, 280));
               ebytes = 3'd1;
            end
            default: count = 16'($urandom_range(0, 24));
         endcase
         case ($urandom_range(0, 9))
            0:       origin = 16'($urandom);
            1:       origin = 16'hFFFF;
            2, 3, 4: origin = 16'($urandom_range(1, 4));
            default: origin = 16'd0;
         endcase
         case ($urandom_range(0, 9))
            0:       npix = 32'd0;
            1:       npix = 32'd1;
            default: npix = $urandom_range(2, 20);
         endcase
         case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 5;
            2:       idle_pct = 20;
            default: idle_pct = 50;
         endcase
         write_all(mode, pbytes, ebytes, count, origin, npix);
         phase_start = stim_bytes;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(10, 40)) push_byte(8'($urandom));
            finish_frame();
         end
         while (stim_bytes - phase_start < 100) begin
            push_frame();
            if ($urandom_range(0, 5) == 0) wait_drained();
         end
         settle();
      end

      // Closing stretch at full rate: a frame too long to finish, long runs included
      idle_pct = 0;
      write_all(MODE_RLE, 3'd3, 3'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
      repeat (30) begin
         run = 1'($urandom_range(0, 1));
         packet = run ? $urandom_range(1, 128) : $urandom_range(1, 4);
         if (run && $urandom_range(0, 3) == 0) packet = 128;
         push_byte({run, 7'(packet - 1)});
         if (run) push_value(0);
         else repeat (packet) push_value(0);
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("targa_pixel_stream_decoder test passed");
      end else begin
         $display("targa_pixel_stream_decoder test failed");
      end
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("targa_pixel_stream_decoder test failed");
      $finish;
   end

endmodule
